// ----- hw/rtl/calendar_clock_counter_defines.svh -----
// Assertion macros for the calendar clock counter.
// The clock is i_clk and the reset is i_rst_n in every module that uses them.
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define CAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CAL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CAL_ASSERT(lbl, prop, msg)
`define CAL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/cal_clk_pkg.sv -----
package cal_clk_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_DATE = 2'd1;
    localparam logic [1:0] CMD_SET_TIME = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MONTH  = 3'd1,
        ST_BAD_DAY    = 3'd2,
        ST_BAD_HOUR   = 3'd3,
        ST_BAD_MINUTE = 3'd4,
        ST_BAD_SECOND = 3'd5
    } t_status;

    localparam logic [5:0]  LAST_SECOND = 6'd59;
    localparam logic [5:0]  LAST_MINUTE = 6'd59;
    localparam logic [4:0]  LAST_HOUR   = 5'd23;
    localparam logic [3:0]  LAST_MONTH  = 4'd12;
    localparam logic [3:0]  FEBRUARY    = 4'd2;
    localparam logic [15:0] YEAR_RESET  = 16'd2000;

    // Multiplicative inverse of 25 modulo 2^16. A 16-bit year is a multiple
    // of 25 exactly when year * inverse (mod 2^16) is at most 65535 / 25.
    localparam logic [15:0] INV_25   = 16'h5C29;
    localparam logic [15:0] MAX_Q_25 = 16'd2621;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Gregorian rule: multiple of 4, and not of 100 unless also of 400.
    // Multiple of 100 is multiple of 4 and 25; of 400 is multiple of 16 and 25.
    function automatic logic f_is_leap(input logic [15:0] year);
        logic [15:0] prod;
        logic        div25;
        prod  = year * INV_25;
        div25 = (prod <= MAX_Q_25);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] f_month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[month];
        if ((month == FEBRUARY) && leap) begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

// ----- hw/rtl/cal_clk_if.sv -----
interface cal_clk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] new_year;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;

    modport source (
        output valid, command, new_month, new_day, new_year,
               new_hour, new_minute, new_second,
        input  ready
    );
    modport sink (
        input  valid, command, new_month, new_day, new_year,
               new_hour, new_minute, new_second,
        output ready
    );
endinterface

interface cal_clk_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;

    modport source (
        output valid, status, cur_year, cur_month, cur_day,
               cur_hour, cur_minute, cur_second,
        input  ready
    );
    modport sink (
        input  valid, status, cur_year, cur_month, cur_day,
               cur_hour, cur_minute, cur_second,
        output ready
    );
endinterface

// ----- hw/rtl/calendar_clock_counter.sv -----
// Calendar clock counter with Gregorian leap years.
// Input channel i_cmd carries one command per transaction: tick one second,
// set date (month, day, year) or set time (hour, minute, second). Command 3
// changes nothing. Output channel o_res returns one transaction per command
// with a status code and the date and time after the command.
// A set whose operands are out of range leaves the calendar unchanged and
// reports the first failing field in the status.
// The result is registered and valid in the cycle after the command is accepted.
// Throughput: one command per cycle while the results are taken; the whole update is one pass of
// compare and increment logic from the calendar registers back into them.
// The output register is the calendar itself plus a status register, so a
// new command is taken whenever the output is empty or being taken in the
// same cycle. While the receiver stalls, i_cmd.ready stays low and the
// calendar holds.
// Reset (synchronous, active low) sets 2000-01-01 00:00:00 and empties the
// output register.
`include "calendar_clock_counter_defines.svh"

module calendar_clock_counter
    import cal_clk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cal_clk_in_if.sink        i_cmd,
    cal_clk_out_if.source     o_res
);

    logic [5:0]  r_second, n_second;
    logic [5:0]  r_minute, n_minute;
    logic [4:0]  r_hour,   n_hour;
    logic [4:0]  r_day,    n_day;
    logic [3:0]  r_month,  n_month;
    logic [15:0] r_year,   n_year;
    t_status     r_status, n_status;
    logic        r_out_valid;

    logic        in_fire;
    logic        cur_leap;
    logic [4:0]  cur_len;
    logic        set_leap;
    logic [4:0]  set_len;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    assign cur_leap = f_is_leap(r_year);
    assign cur_len  = f_month_days(r_month, cur_leap);
    assign set_leap = f_is_leap(i_cmd.new_year);
    assign set_len  = f_month_days(i_cmd.new_month, set_leap);

    always_comb begin
        n_second = r_second;
        n_minute = r_minute;
        n_hour   = r_hour;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_status = ST_OK;
        case (i_cmd.command)
            CMD_TICK: begin
                if (r_second < LAST_SECOND) begin
                    n_second = r_second + 6'd1;
                end else begin
                    n_second = '0;
                    if (r_minute < LAST_MINUTE) begin
                        n_minute = r_minute + 6'd1;
                    end else begin
                        n_minute = '0;
                        if (r_hour < LAST_HOUR) begin
                            n_hour = r_hour + 5'd1;
                        end else begin
                            n_hour = '0;
                            if (r_day >= cur_len) begin
                                n_day = 5'd1;
                                if (r_month >= LAST_MONTH) begin
                                    n_month = 4'd1;
                                    n_year  = r_year + 16'd1;
                                end else begin
                                    n_month = r_month + 4'd1;
                                end
                            end else begin
                                n_day = r_day + 5'd1;
                            end
                        end
                    end
                end
            end
            CMD_SET_DATE: begin
                if ((i_cmd.new_month == 4'd0) || (i_cmd.new_month > LAST_MONTH)) begin
                    n_status = ST_BAD_MONTH;
                end else if ((i_cmd.new_day == 5'd0) || (i_cmd.new_day > set_len)) begin
                    n_status = ST_BAD_DAY;
                end else begin
                    n_month = i_cmd.new_month;
                    n_day   = i_cmd.new_day;
                    n_year  = i_cmd.new_year;
                end
            end
            CMD_SET_TIME: begin
                if (i_cmd.new_hour > LAST_HOUR) begin
                    n_status = ST_BAD_HOUR;
                end else if (i_cmd.new_minute > LAST_MINUTE) begin
                    n_status = ST_BAD_MINUTE;
                end else if (i_cmd.new_second > LAST_SECOND) begin
                    n_status = ST_BAD_SECOND;
                end else begin
                    n_hour   = i_cmd.new_hour;
                    n_minute = i_cmd.new_minute;
                    n_second = i_cmd.new_second;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second    <= '0;
            r_minute    <= '0;
            r_hour      <= '0;
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= YEAR_RESET;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_second    <= n_second;
                r_minute    <= n_minute;
                r_hour      <= n_hour;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.cur_year   = r_year;
    assign o_res.cur_month  = r_month;
    assign o_res.cur_day    = r_day;
    assign o_res.cur_hour   = r_hour;
    assign o_res.cur_minute = r_minute;
    assign o_res.cur_second = r_second;

    `CAL_ASSERT(a_calendar_in_range,
        (r_second <= LAST_SECOND) && (r_minute <= LAST_MINUTE) && (r_hour <= LAST_HOUR)
            && (r_month != 4'd0) && (r_month <= LAST_MONTH)
            && (r_day != 5'd0) && (r_day <= cur_len),
        "calendar register out of range")
    `CAL_ASSERT(a_result_follows, in_fire |=> r_out_valid, "accepted transaction gave no result")
    `CAL_ASSERT(a_reject_holds_time,
        (in_fire && (i_cmd.command == CMD_SET_TIME) && (n_status != ST_OK))
            |=> ($stable(r_hour) && $stable(r_minute) && $stable(r_second)),
        "rejected time set changed the clock")
    `CAL_ASSERT(a_tick_second,
        (in_fire && (i_cmd.command == CMD_TICK) && (r_second < LAST_SECOND))
            |=> ((r_second == $past(r_second) + 6'd1) && $stable(r_minute)),
        "tick did not advance the second")
    `CAL_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule
